// File: sv/assert_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every clock edge outside reset.
`define SED_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SED_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SED_ASSERT(lbl, prop, msg)
`define SED_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: sv/sed_pkg.sv
// Shared types and constants of the response deframer.
package sed_pkg;

    // Frame bytes and limits
    localparam logic [7:0] SOH_BYTE          = 8'h01;
    localparam logic [7:0] EOT_BYTE          = 8'h04;
    localparam logic [7:0] UNSUPPORTED_INDEX = 8'hEE;
    localparam logic [7:0] HEADER_LEN        = 8'd3;
    localparam int         MAX_DATA          = 252;
    // Largest legal size byte, one bit wider so the sum cannot wrap
    localparam logic [8:0] SIZE_LIMIT        = 9'(MAX_DATA) + 9'(HEADER_LEN);

    // Frame status codes
    localparam logic [3:0] ST_OK           = 4'd0;
    localparam logic [3:0] ST_BAD_START    = 4'd1;
    localparam logic [3:0] ST_BAD_SIZE     = 4'd2;
    localparam logic [3:0] ST_BAD_END      = 4'd3;
    localparam logic [3:0] ST_UNSUPPORTED  = 4'd4;
    localparam logic [3:0] ST_INDEX_MISM   = 4'd5;
    localparam logic [3:0] ST_COMMAND_MISM = 4'd6;
    localparam logic [3:0] ST_LENGTH_MISM  = 4'd7;
    localparam logic [3:0] ST_TIMEOUT      = 4'd8;

    // Input kinds and result kinds
    localparam logic OP_BYTE     = 1'b0;
    localparam logic OP_TIMEOUT  = 1'b1;
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 2;
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_EXP_INDEX   = 2'd0,
        CFG_EXP_COMMAND = 2'd1,
        CFG_LEN_CHECK   = 2'd2,
        CFG_EXP_LENGTH  = 2'd3
    } cfg_index_t;

    // Receive phase, one-hot
    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_SIZE    = 6'b000010,
        PH_INDEX   = 6'b000100,
        PH_COMMAND = 6'b001000,
        PH_DATA    = 6'b010000,
        PH_END     = 6'b100000
    } phase_t;

    // One result item as it travels from front end to output stage
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] byte_position;
        logic [3:0] frame_status;
        logic [7:0] frame_index;
        logic [7:0] frame_command;
        logic [7:0] data_length;
        logic       last;
    } result_t;

    // Result queue and output bus sizes
    localparam int QUEUE_DEPTH = 2;
    localparam int TDATA_W     = 48;
    localparam int FIELDS_W    = 44;

endpackage

// File: sv/sed_front.sv
// Front end: configuration registers, frame phase machine and result classification.
`include "assert_macros.svh"

module sed_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_fire,
    input  logic                           opcode,
    input  logic [7:0]                     rx_byte,
    input  logic                           cfg_fire,
    input  logic [sed_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [7:0]                     cfg_wdata,
    output logic                           push,
    output sed_pkg::result_t               result
);
    import sed_pkg::*;

    logic [7:0] exp_index_reg;
    logic [7:0] exp_command_reg;
    logic       len_check_reg;
    logic [7:0] exp_length_reg;

    phase_t     phase_reg, phase_next;
    logic [7:0] length_seen_reg, length_seen_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] index_seen_reg, index_seen_next;
    logic [7:0] command_seen_reg, command_seen_next;
    logic [7:0] bytes_left_dec;
    logic [3:0] end_status;
    logic [3:0] status;
    logic       emit_status;
    logic       emit_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_index_reg   <= 8'd1;
            exp_command_reg <= 8'd64;
            len_check_reg   <= 1'b0;
            exp_length_reg  <= 8'd0;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_EXP_INDEX:   exp_index_reg   <= cfg_wdata;
                CFG_EXP_COMMAND: exp_command_reg <= cfg_wdata;
                CFG_LEN_CHECK:   len_check_reg   <= cfg_wdata[0];
                CFG_EXP_LENGTH:  exp_length_reg  <= cfg_wdata;
                default:         exp_command_reg <= exp_command_reg;
            endcase
        end
    end

    // Status at the end byte, in priority order
    always_comb
    begin
        if (rx_byte != EOT_BYTE)
            end_status = ST_BAD_END;
        else if (exp_index_reg != UNSUPPORTED_INDEX && index_seen_reg == UNSUPPORTED_INDEX)
            end_status = ST_UNSUPPORTED;
        else if (index_seen_reg != exp_index_reg)
            end_status = ST_INDEX_MISM;
        else if (command_seen_reg != exp_command_reg)
            end_status = ST_COMMAND_MISM;
        else if (len_check_reg && length_seen_reg != exp_length_reg)
            end_status = ST_LENGTH_MISM;
        else
            end_status = ST_OK;
    end

    assign bytes_left_dec = (bytes_left_reg != 8'd0) ? bytes_left_reg - 8'd1 : bytes_left_reg;

    // Phase machine: one received byte or timeout per accepted transaction
    always_comb
    begin
        phase_next        = phase_reg;
        length_seen_next  = length_seen_reg;
        bytes_left_next   = bytes_left_reg;
        index_seen_next   = index_seen_reg;
        command_seen_next = command_seen_reg;
        emit_status       = 1'b0;
        emit_data         = 1'b0;
        status            = ST_OK;
        if (opcode == OP_TIMEOUT)
        begin
            emit_status = 1'b1;
            status      = ST_TIMEOUT;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (rx_byte != SOH_BYTE)
                    begin
                        emit_status = 1'b1;
                        status      = ST_BAD_START;
                    end
                    else
                        phase_next = PH_SIZE;
                end
                PH_SIZE:
                begin
                    if (rx_byte < HEADER_LEN || {1'b0, rx_byte} > SIZE_LIMIT)
                    begin
                        emit_status = 1'b1;
                        status      = ST_BAD_SIZE;
                    end
                    else
                    begin
                        length_seen_next = rx_byte - HEADER_LEN;
                        bytes_left_next  = rx_byte - HEADER_LEN;
                        phase_next       = PH_INDEX;
                    end
                end
                PH_INDEX:
                begin
                    index_seen_next = rx_byte;
                    phase_next      = PH_COMMAND;
                end
                PH_COMMAND:
                begin
                    command_seen_next = rx_byte;
                    phase_next        = (bytes_left_reg != 8'd0) ? PH_DATA : PH_END;
                end
                PH_DATA:
                begin
                    emit_data       = 1'b1;
                    bytes_left_next = bytes_left_dec;
                    if (bytes_left_dec == 8'd0)
                        phase_next = PH_END;
                end
                PH_END:
                begin
                    emit_status = 1'b1;
                    status      = end_status;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        // Every status closes the frame and clears it
        if (emit_status)
        begin
            phase_next        = PH_IDLE;
            length_seen_next  = 8'd0;
            bytes_left_next   = 8'd0;
            index_seen_next   = 8'd0;
            command_seen_next = 8'd0;
        end
    end

    // Frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            length_seen_reg  <= 8'd0;
            bytes_left_reg   <= 8'd0;
            index_seen_reg   <= 8'd0;
            command_seen_reg <= 8'd0;
        end
        else if (in_fire)
        begin
            phase_reg        <= phase_next;
            length_seen_reg  <= length_seen_next;
            bytes_left_reg   <= bytes_left_next;
            index_seen_reg   <= index_seen_next;
            command_seen_reg <= command_seen_next;
        end
    end

    // Result record, fields taken before the frame is cleared
    assign push = in_fire && (emit_status || emit_data);

    always_comb
    begin
        result.kind          = emit_status ? KIND_STATUS : KIND_DATA;
        result.data_byte     = emit_status ? 8'd0 : rx_byte;
        result.byte_position = emit_status ? 8'd0 : (length_seen_reg - bytes_left_reg);
        result.frame_status  = status;
        result.frame_index   = index_seen_reg;
        result.frame_command = command_seen_reg;
        result.data_length   = length_seen_reg;
        result.last          = emit_status;
    end

    `SED_ASSERT(a_status_clears_frame, push && result.last |=> phase_reg == PH_IDLE && bytes_left_reg == 8'd0, "status did not return the frame to idle")
    `SED_ASSERT(a_data_only_in_data_phase, push && result.kind == KIND_DATA |-> phase_reg == PH_DATA, "data result outside data phase")
    `SED_ASSERT(a_data_phase_has_bytes, phase_reg == PH_DATA |-> bytes_left_reg != 8'd0, "data phase with no bytes left")

endmodule

// File: sv/sed_queue.sv
// Two-entry result queue between the front end and the output stage.
`include "assert_macros.svh"

module sed_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sed_pkg::result_t push_data,
    input  logic             pop,
    output sed_pkg::result_t pop_data,
    output logic             empty,
    output logic             full
);
    import sed_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    result_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_data = entry_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    `SED_ASSERT(a_count_in_range, count_reg <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
    `SED_ASSERT(a_no_overflow, push |-> !full, "push into a full queue")
    `SED_ASSERT(a_no_underflow, pop |-> !empty, "pop from an empty queue")

endmodule

// File: sv/sed_back.sv
// Output stage: takes results from the queue and holds them on the master stream.
module sed_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           queue_empty,
    input  sed_pkg::result_t               queue_data,
    output logic                           queue_pop,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [sed_pkg::TDATA_W-1:0]    m_axis_tdata,
    output logic                           m_axis_tuser,
    output logic                           m_axis_tlast
);
    import sed_pkg::*;

    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    // Refill the output register when it is empty or being taken
    assign queue_pop      = !queue_empty && (!out_valid_reg || m_axis_tready);
    assign out_valid_next = queue_pop || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (queue_pop)
            out_reg <= queue_data;
    end

    // Bus packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = {(TDATA_W - FIELDS_W)'(0),
                            out_reg.data_length,
                            out_reg.frame_command,
                            out_reg.frame_index,
                            out_reg.frame_status,
                            out_reg.byte_position,
                            out_reg.data_byte};

endmodule

// File: sv/soh_eot_response_deframer.sv
// Top level of the SOH/EOT serial response deframer.
// Usage:
//   s_axis carries one transaction per received serial event: tuser is the
//   kind (0 received byte, 1 receive timeout), tdata[7:0] the byte.
//   m_axis carries at most one result per input transaction: tuser 0 is a
//   data byte of the frame, tuser 1 a frame status with tlast set.
//   cfg_valid/cfg_ready write cfg_data into register cfg_index: 0 expected
//   index, 1 expected command, 2 length check enable, 3 expected length.
//   Write configuration only while no transaction is in flight.
// Timing:
//   Input is taken every cycle while the result queue has room; a byte is
//   classified in the cycle it is accepted; its result is then registered
//   in the queue and the output register. Sustained rate is one transaction
//   per cycle while m_axis_tready is high, set by the front phase machine.
// Reset clears the phase machine to idle (hunting for SOH), empties the
// queue and the output register, and loads the register reset values.
// When the receiver stalls, the output register holds its transaction, the
// two-entry queue fills, and s_axis_tready drops until space frees up.
module soh_eot_response_deframer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // [7:0] rx_byte
    input  logic                           s_axis_tuser,  // [0] opcode
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [7:0] data_byte, [15:8] byte_position, [19:16] frame_status,
    // [27:20] frame_index, [35:28] frame_command, [43:36] data_length, rest zero
    output logic [sed_pkg::TDATA_W-1:0]    m_axis_tdata,
    output logic                           m_axis_tuser,  // [0] result_kind
    output logic                           m_axis_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sed_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);
    import sed_pkg::*;

    logic    in_fire;
    logic    push;
    result_t push_data;
    logic    pop;
    result_t pop_data;
    logic    q_empty;
    logic    q_full;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !q_full;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    sed_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .opcode    (s_axis_tuser),
        .rx_byte   (s_axis_tdata),
        .cfg_fire  (cfg_valid && cfg_ready),
        .cfg_addr  (cfg_index),
        .cfg_wdata (cfg_data),
        .push      (push),
        .result    (push_data)
    );

    sed_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    sed_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .queue_empty   (q_empty),
        .queue_data    (pop_data),
        .queue_pop     (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the SOH/EOT response deframer.
`timescale 1ns / 1ps

module tb_top;
    import sed_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int QUIET_LIMIT     = 3000;
    localparam int PRESSURE_CYCLES = 120;
    localparam int SETTLE_CYCLES   = 8;

    // Frame checker: tracks the receive phase machine and the expected results
    class frame_checker;
        logic [7:0] exp_index   = 8'd1;
        logic [7:0] exp_command = 8'd64;
        logic       len_check   = 1'b0;
        logic [7:0] exp_length  = 8'd0;

        phase_t     rx_phase    = PH_IDLE;
        logic [7:0] data_len    = '0;
        logic [7:0] remaining   = '0;
        logic [7:0] hdr_index   = '0;
        logic [7:0] hdr_command = '0;

        result_t    frame_results_due[$];
        int         errors         = 0;
        int         results_seen   = 0;
        int         data_results   = 0;
        int         status_results = 0;
        logic [8:0] statuses_hit   = '0;

        task report(string msg);
            if (errors < 30)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        function void set_register(cfg_index_t idx, logic [7:0] val);
            case (idx)
                CFG_EXP_INDEX:   exp_index   = val;
                CFG_EXP_COMMAND: exp_command = val;
                CFG_LEN_CHECK:   len_check   = val[0];
                CFG_EXP_LENGTH:  exp_length  = val;
                default: ;
            endcase
        endfunction

        function void clear_frame();
            rx_phase    = PH_IDLE;
            data_len    = '0;
            remaining   = '0;
            hdr_index   = '0;
            hdr_command = '0;
        endfunction

        // Status item that closes the frame; state returns to idle
        function result_t close_frame(logic [3:0] st);
            result_t r;
            r = '0;
            r.kind          = KIND_STATUS;
            r.frame_status  = st;
            r.frame_index   = hdr_index;
            r.frame_command = hdr_command;
            r.data_length   = data_len;
            r.last          = 1'b1;
            clear_frame();
            return r;
        endfunction

        // Status at the end byte, highest priority first
        function logic [3:0] end_status(logic [7:0] rx);
            if (rx != EOT_BYTE)
                return ST_BAD_END;
            if (exp_index != UNSUPPORTED_INDEX && hdr_index == UNSUPPORTED_INDEX)
                return ST_UNSUPPORTED;
            if (hdr_index != exp_index)
                return ST_INDEX_MISM;
            if (hdr_command != exp_command)
                return ST_COMMAND_MISM;
            if (len_check && data_len != exp_length)
                return ST_LENGTH_MISM;
            return ST_OK;
        endfunction

        // Advance the phase machine by one accepted input transaction
        function void take_rx_item(logic op, logic [7:0] rx);
            result_t r;
            logic    emit;
            r    = '0;
            emit = 1'b0;
            if (op == OP_TIMEOUT) begin
                r    = close_frame(ST_TIMEOUT);
                emit = 1'b1;
            end
            else begin
                case (rx_phase)
                    PH_IDLE:
                        if (rx != SOH_BYTE) begin
                            r    = close_frame(ST_BAD_START);
                            emit = 1'b1;
                        end
                        else
                            rx_phase = PH_SIZE;
                    PH_SIZE:
                        if (rx < HEADER_LEN || {1'b0, rx} > SIZE_LIMIT) begin
                            r    = close_frame(ST_BAD_SIZE);
                            emit = 1'b1;
                        end
                        else begin
                            data_len  = rx - HEADER_LEN;
                            remaining = rx - HEADER_LEN;
                            rx_phase  = PH_INDEX;
                        end
                    PH_INDEX:
                    begin
                        hdr_index = rx;
                        rx_phase  = PH_COMMAND;
                    end
                    PH_COMMAND:
                    begin
                        hdr_command = rx;
                        rx_phase    = (remaining != 0) ? PH_DATA : PH_END;
                    end
                    PH_DATA:
                    begin
                        r.kind          = KIND_DATA;
                        r.data_byte     = rx;
                        r.byte_position = data_len - remaining;
                        r.frame_index   = hdr_index;
                        r.frame_command = hdr_command;
                        r.data_length   = data_len;
                        r.last          = 1'b0;
                        emit            = 1'b1;
                        if (remaining != 0)
                            remaining = remaining - 8'd1;
                        if (remaining == 0)
                            rx_phase = PH_END;
                    end
                    PH_END:
                    begin
                        r    = close_frame(end_status(rx));
                        emit = 1'b1;
                    end
                    default:
                        clear_frame();
                endcase
            end
            if (emit)
                frame_results_due.push_back(r);
        endfunction

        // Compare one output transaction with the oldest expectation
        task check_rx_result(logic kind, logic [TDATA_W-1:0] data, logic tl);
            result_t got;
            result_t want;
            got.kind          = kind;
            got.data_byte     = data[7:0];
            got.byte_position = data[15:8];
            got.frame_status  = data[19:16];
            got.frame_index   = data[27:20];
            got.frame_command = data[35:28];
            got.data_length   = data[43:36];
            got.last          = tl;
            results_seen++;
            if (data[TDATA_W-1:FIELDS_W] !== '0)
                report($sformatf("tdata padding not zero: %h", data));
            if (frame_results_due.size() == 0) begin
                report($sformatf("result with nothing expected: kind=%0d tdata=%h",
                                 kind, data));
                return;
            end
            want = frame_results_due.pop_front();
            if (want.kind == KIND_STATUS) begin
                status_results++;
                statuses_hit[want.frame_status] = 1'b1;
            end
            else
                data_results++;
            if (got !== want)
                report($sformatf({"got kind=%0d byte=%h pos=%0d st=%0d idx=%h cmd=%h len=%0d",
                                  " last=%0d / want kind=%0d byte=%h pos=%0d st=%0d idx=%h",
                                  " cmd=%h len=%0d last=%0d"},
                                 got.kind, got.data_byte, got.byte_position,
                                 got.frame_status, got.frame_index, got.frame_command,
                                 got.data_length, got.last,
                                 want.kind, want.data_byte, want.byte_position,
                                 want.frame_status, want.frame_index, want.frame_command,
                                 want.data_length, want.last));
        endtask
    endclass

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_index     = '0;
    logic [7:0]            cfg_data      = '0;

    frame_checker sb = new();
    int           items_sent = 0;
    int           quiet      = 0;

    soh_eot_response_deframer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // One input transaction; every third stretch of 40 runs back to back
    task automatic send_item(input logic op, input logic [7:0] rx);
        int gap;
        gap = (((items_sent / 40) % 3) == 2) ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= rx;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.take_rx_item(op, rx);
        items_sent++;
    endtask

    // Frame with random payload; a timeout replaces the byte at position cut
    task automatic send_frame(input logic [7:0] size_b, input logic [7:0] idx,
                              input logic [7:0] cmd, input logic [7:0] end_b,
                              input int cut);
        logic [7:0] seq[$];
        int         n;
        seq.push_back(SOH_BYTE);
        seq.push_back(size_b);
        if (size_b >= HEADER_LEN) begin
            seq.push_back(idx);
            seq.push_back(cmd);
            n = int'(size_b - HEADER_LEN);
            repeat (n) seq.push_back(8'($urandom));
            seq.push_back(end_b);
        end
        foreach (seq[i]) begin
            if (i == cut) begin
                send_item(OP_TIMEOUT, 8'($urandom));
                return;
            end
            send_item(OP_BYTE, seq[i]);
        end
    endtask

    // Mostly well-formed frames, with noise and broken frames mixed in
    task automatic send_random_frame();
        int         pick;
        int         n;
        int         cut;
        int         r;
        logic [7:0] idx;
        logic [7:0] cmd;
        logic [7:0] end_b;
        logic [7:0] size_b;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            repeat ($urandom_range(1, 3)) send_item(OP_BYTE, 8'($urandom));
            return;
        end
        if (pick < 9) begin
            send_item(OP_TIMEOUT, 8'($urandom));
            return;
        end
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        if (sb.len_check && $urandom_range(0, 1) == 1 && sb.exp_length <= 40)
            n = int'(sb.exp_length);
        size_b = 8'(n) + HEADER_LEN;
        if (pick < 16)
            size_b = 8'($urandom_range(0, 2));
        r = $urandom_range(0, 99);
        if (r < 70)
            idx = sb.exp_index;
        else if (r < 76)
            idx = UNSUPPORTED_INDEX;
        else
            idx = 8'($urandom);
        cmd = ($urandom_range(0, 99) < 75) ? sb.exp_command : 8'($urandom);
        end_b = EOT_BYTE;
        if (pick >= 16 && pick < 24) begin
            end_b = 8'($urandom);
            if (end_b == EOT_BYTE)
                end_b = 8'h00;
        end
        cut = (pick >= 24 && pick < 30) ? $urandom_range(0, n + 4) : -1;
        send_frame(size_b, idx, cmd, end_b, cut);
    endtask

    task automatic run_random(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
            send_random_frame();
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_all(input logic [7:0] idx, input logic [7:0] cmd,
                           input logic chk, input logic [7:0] len);
        write_reg(CFG_EXP_INDEX, idx);
        write_reg(CFG_EXP_COMMAND, cmd);
        write_reg(CFG_LEN_CHECK, {7'd0, chk});
        write_reg(CFG_EXP_LENGTH, len);
    endtask

    // Stop offering, wait for every expected result, then let the pipe drain
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.frame_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Output monitor
    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_rx_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Receiver ready: random bursts and stalls, plus one long hold-off
    initial begin : ready_drive
        int run;
        int stall;
        bit pressure_done;
        pressure_done = 1'b0;
        @(posedge rst_n);
        forever begin
            if (!pressure_done && sb.results_seen >= 60) begin
                pressure_done = 1'b1;
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (PRESSURE_CYCLES - 1) @(negedge clk);
            end
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
            @(negedge clk);
            m_axis_tready <= 1'b1;
            repeat (run - 1) @(negedge clk);
            stall = pick_gap();
            if (stall > 0) begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
        end
    end

    // Stimulus sequence
    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed frames under reset register values
        send_item(OP_TIMEOUT, 8'h00);                      // timeout while idle
        send_item(OP_BYTE, 8'hFF);                         // wrong start byte
        send_frame(8'h02, 8'h01, 8'h40, EOT_BYTE, -1);     // size below header
        send_frame(8'h05, 8'h01, 8'h40, EOT_BYTE, -1);     // good, two data bytes
        send_frame(8'h03, 8'h01, 8'h40, 8'h80, -1);        // wrong end byte
        send_frame(8'h03, UNSUPPORTED_INDEX, 8'h40, EOT_BYTE, -1);
        send_frame(8'h04, 8'h01, 8'h40, EOT_BYTE, 3);      // timeout in header
        settle();

        // Unsupported index expected, zero-length check
        set_all(UNSUPPORTED_INDEX, 8'h00, 1'b1, 8'd0);
        run_random(40);
        settle();

        // Largest frame, matching length of MAX_DATA
        set_all(8'h00, 8'hFF, 1'b1, 8'(MAX_DATA));
        send_frame(8'hFF, 8'h00, 8'hFF, EOT_BYTE, -1);
        run_random(20);
        settle();

        // Expected length beyond the data limit never matches
        set_all(8'hFF, 8'h5A, 1'b1, 8'hFF);
        run_random(30);
        settle();

        // Back near defaults, length check off
        set_all(8'h01, 8'h40, 1'b0, 8'h07);
        run_random(40);
        settle();

        if (sb.frame_results_due.size() != 0)
            sb.report($sformatf("%0d expected results never arrived",
                                sb.frame_results_due.size()));
        $display("Run covered %0d input transactions, %0d data and %0d status results.",
                 items_sent, sb.data_results, sb.status_results);
        $display("Status codes seen (bit per code, 8..0): %b", sb.statuses_hit);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: soh_eot_response_deframer.f
+incdir+sv
sv/sed_pkg.sv
sv/sed_front.sv
sv/sed_queue.sv
sv/sed_back.sv
sv/soh_eot_response_deframer.sv
test/tb_top.sv
